>>> rtl/sphere_elastic_collision_assert.svh
// assertion macros used by the checker file
`ifndef SPHERE_ELASTIC_COLLISION_ASSERT_SVH
`define SPHERE_ELASTIC_COLLISION_ASSERT_SVH

// same-cycle implication
`define SEC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sphere_elastic_collision: check failed");

// next-cycle implication
`define SEC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sphere_elastic_collision: check failed");

`endif

>>> rtl/sec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sec_pkg;

    localparam int PROJ_QW = 33;
    localparam int PROJ_DW = 64;
    localparam int PROJ_NW = 96;

    localparam int MASS_QW = 35;
    localparam int MASS_DW = 17;
    localparam int MASS_NW = 52;

    localparam int PRE_STAGES = 5;
    localparam int MID_STAGES = 3;
    localparam int DEPTH      = PRE_STAGES + PROJ_QW + MID_STAGES + MASS_QW + 2;

    typedef struct packed {
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_a_z;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic signed [31:0] vel_b_z;
        logic        [30:0] radius_sum;
        logic        [15:0] mass_a;
        logic        [15:0] mass_b;
    } pair_t;

    typedef struct packed {
        logic signed [31:0] new_vel_a_x;
        logic signed [31:0] new_vel_a_y;
        logic signed [31:0] new_vel_a_z;
        logic signed [31:0] new_vel_b_x;
        logic signed [31:0] new_vel_b_y;
        logic signed [31:0] new_vel_b_z;
        logic               contact;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/sec_proj_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sec_proj_div (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [5:0][sec_pkg::PROJ_NW-1:0]        num,
    input  logic [sec_pkg::PROJ_DW-1:0]             den,
    output logic [5:0][sec_pkg::PROJ_QW-1:0]        quot
);

    localparam int QW = sec_pkg::PROJ_QW;
    localparam int DW = sec_pkg::PROJ_DW;
    localparam int NW = sec_pkg::PROJ_NW;

    logic [5:0][DW-1:0] rem_reg [QW-1];
    logic [DW-1:0]      den_reg [QW-1];
    logic [5:0][QW-1:0] low_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [5:0][DW-1:0] rem_in;
        logic [5:0][QW-1:0] low_in;
        logic [DW-1:0]      den_in;
        logic [5:0][DW:0]   trial;
        logic [5:0]         take;
        logic [5:0][QW-1:0] low_next;

        if (k == 0)
        begin : g_load
            always_comb
            begin
                for (int l = 0; l < 6; l++)
                begin
                    rem_in[l] = DW'(num[l][NW-1:QW]);
                    low_in[l] = num[l][QW-1:0];
                end
            end
            assign den_in = den;
        end
        else
        begin : g_chain
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb
        begin
            for (int l = 0; l < 6; l++)
            begin
                trial[l]    = {rem_in[l], low_in[l][QW-1]};
                take[l]     = trial[l] >= {1'b0, den_in};
                low_next[l] = {low_in[l][QW-2:0], take[l]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[k] <= low_next;
            end
        end

        if (k < QW - 1)
        begin : g_keep
            logic [5:0][DW-1:0] rem_next;

            always_comb
            begin
                for (int l = 0; l < 6; l++)
                begin
                    rem_next[l] = take[l] ? DW'(trial[l] - {1'b0, den_in}) : DW'(trial[l]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quot = low_reg[QW-1];

endmodule

`default_nettype wire

>>> rtl/sec_mass_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sec_mass_div (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [5:0][sec_pkg::MASS_NW-1:0]        num,
    input  logic [sec_pkg::MASS_DW-1:0]             den,
    output logic [5:0][sec_pkg::MASS_QW-1:0]        quot
);

    localparam int QW = sec_pkg::MASS_QW;
    localparam int DW = sec_pkg::MASS_DW;
    localparam int NW = sec_pkg::MASS_NW;

    logic [5:0][DW-1:0] rem_reg [QW-1];
    logic [DW-1:0]      den_reg [QW-1];
    logic [5:0][QW-1:0] low_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [5:0][DW-1:0] rem_in;
        logic [5:0][QW-1:0] low_in;
        logic [DW-1:0]      den_in;
        logic [5:0][DW:0]   trial;
        logic [5:0]         take;
        logic [5:0][QW-1:0] low_next;

        if (k == 0)
        begin : g_load
            always_comb
            begin
                for (int l = 0; l < 6; l++)
                begin
                    rem_in[l] = DW'(num[l][NW-1:QW]);
                    low_in[l] = num[l][QW-1:0];
                end
            end
            assign den_in = den;
        end
        else
        begin : g_chain
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb
        begin
            for (int l = 0; l < 6; l++)
            begin
                trial[l]    = {rem_in[l], low_in[l][QW-1]};
                take[l]     = trial[l] >= {1'b0, den_in};
                low_next[l] = {low_in[l][QW-2:0], take[l]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[k] <= low_next;
            end
        end

        if (k < QW - 1)
        begin : g_keep
            logic [5:0][DW-1:0] rem_next;

            always_comb
            begin
                for (int l = 0; l < 6; l++)
                begin
                    rem_next[l] = take[l] ? DW'(trial[l] - {1'b0, den_in}) : DW'(trial[l]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quot = low_reg[QW-1];

endmodule

`default_nettype wire

>>> rtl/sphere_elastic_collision.sv
// channel   signals                         payload
// request   pair_valid / pair_stall         pair   (sec_pkg::pair_t)
// result    result_valid / result_stall     result (sec_pkg::result_t)
//
// one request per cycle sustained unless a stalled result holds the pipe
// the pipe holds the 33-stage projection divider and the 35-stage mass divider
// rst_n clears only the stage valid bits, payload registers are not reset
// a stalled result freezes the whole pipe; an empty input stage still takes a request
`timescale 1ns / 1ps
`default_nettype none

module sphere_elastic_collision (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_stall,
    input  sec_pkg::pair_t    pair,
    output logic              result_valid,
    input  logic              result_stall,
    output sec_pkg::result_t  result
);

    localparam int DEPTH = sec_pkg::DEPTH;
    localparam int PQ    = sec_pkg::PROJ_QW;
    localparam int MQ    = sec_pkg::MASS_QW;

    typedef struct packed {
        logic [5:0][31:0] vel;
        logic [15:0]      ma;
        logic [15:0]      mb;
    } kin_t;

    typedef struct packed {
        kin_t       kin;
        logic       contact;
        logic [5:0] nneg;
    } side1_t;

    typedef struct packed {
        logic [5:0][31:0] vel;
        logic [5:0][33:0] nrm;
        logic             contact;
        logic             ms_zero;
        logic [5:0]       xneg;
    } side2_t;

    function automatic logic [31:0] sat32(input logic [36:0] s);
        logic [31:0] r;
        if (s[36] && !(&s[35:31]))
        begin
            r = 32'h8000_0000;
        end
        else if (!s[36] && (|s[35:31]))
        begin
            r = 32'h7fff_ffff;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

    // pipeline control
    logic [DEPTH-1:0] v_reg;
    logic [DEPTH-1:0] v_next;
    logic             en;
    logic             load0;

    assign en           = !v_reg[DEPTH-1] || !result_stall;
    assign load0        = en || !v_reg[0];
    assign pair_stall   = !load0;
    assign result_valid = v_reg[DEPTH-1];

    always_comb
    begin
        v_next = v_reg;
        if (load0)
        begin
            v_next[0] = pair_valid;
        end
        if (en)
        begin
            v_next[DEPTH-1:1] = v_reg[DEPTH-2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // input stage
    sec_pkg::pair_t pair_reg;

    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            pair_reg <= pair;
        end
    end

    // stage a: squares and products
    logic [2:0][31:0] d_w;
    logic [5:0][31:0] vel_w;
    logic [2:0][31:0] dmag_next;
    logic [2:0][63:0] sq_next;
    logic [61:0]      r2_next;
    logic [5:0][63:0] pr_next;
    logic [2:0]       dneg_next;
    kin_t             kin_next;

    logic [2:0][63:0] sq_reg;
    logic [61:0]      r2_reg;
    logic [5:0][63:0] pr_reg;
    logic [2:0]       dneg_a_reg;
    logic [2:0][31:0] dmag_a_reg;
    kin_t             kin_a_reg;

    always_comb
    begin
        d_w   = {pair_reg.rel_z, pair_reg.rel_y, pair_reg.rel_x};
        vel_w = {pair_reg.vel_b_z, pair_reg.vel_b_y, pair_reg.vel_b_x,
                 pair_reg.vel_a_z, pair_reg.vel_a_y, pair_reg.vel_a_x};
        for (int i = 0; i < 3; i++)
        begin
            dneg_next[i] = d_w[i][31];
            dmag_next[i] = d_w[i][31] ? 32'(-d_w[i]) : d_w[i];
            sq_next[i]   = 64'(dmag_next[i]) * 64'(dmag_next[i]);
            for (int j = 0; j < 2; j++)
            begin
                pr_next[3*j+i] = 64'($signed(d_w[i])) * 64'($signed(vel_w[3*j+i]));
            end
        end
        r2_next      = 62'(pair_reg.radius_sum) * 62'(pair_reg.radius_sum);
        kin_next.vel = vel_w;
        kin_next.ma  = pair_reg.mass_a;
        kin_next.mb  = pair_reg.mass_b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg     <= sq_next;
            r2_reg     <= r2_next;
            pr_reg     <= pr_next;
            dneg_a_reg <= dneg_next;
            dmag_a_reg <= dmag_next;
            kin_a_reg  <= kin_next;
        end
    end

    // stage b: squared length, dot products, contact test
    logic [1:0][65:0] dot_w;
    logic [63:0]      l2_next;
    logic [1:0][63:0] dm_next;
    side1_t           s1_b_next;

    logic [63:0]      l2_b_reg;
    logic [1:0][63:0] dm_reg;
    logic [2:0][31:0] dmag_b_reg;
    side1_t           s1_b_reg;

    always_comb
    begin
        l2_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        for (int j = 0; j < 2; j++)
        begin
            dot_w[j] = 66'($signed(pr_reg[3*j])) + 66'($signed(pr_reg[3*j+1]))
                     + 66'($signed(pr_reg[3*j+2]));
            dm_next[j] = dot_w[j][65] ? 64'(-dot_w[j]) : 64'(dot_w[j]);
            for (int i = 0; i < 3; i++)
            begin
                s1_b_next.nneg[3*j+i] = dot_w[j][65] ^ dneg_a_reg[i];
            end
        end
        s1_b_next.kin     = kin_a_reg;
        s1_b_next.contact = (l2_next != '0) && (l2_next < 64'(r2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_b_reg   <= l2_next;
            dm_reg     <= dm_next;
            dmag_b_reg <= dmag_a_reg;
            s1_b_reg   <= s1_b_next;
        end
    end

    // stage c: partial products of the projection numerator
    logic [5:0][63:0] pl_next;
    logic [5:0][63:0] ph_next;
    logic [5:0][63:0] pl_reg;
    logic [5:0][63:0] ph_reg;
    logic [63:0]      l2_c_reg;
    side1_t           s1_c_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_next[3*j+i] = 64'(dm_reg[j][31:0]) * 64'(dmag_b_reg[i]);
                ph_next[3*j+i] = 64'(dm_reg[j][63:32]) * 64'(dmag_b_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            l2_c_reg <= l2_b_reg;
            s1_c_reg <= s1_b_reg;
        end
    end

    // stage d: projection numerator
    logic [5:0][95:0] num_next;
    logic [5:0][95:0] num_reg;
    logic [63:0]      l2_d_reg;
    side1_t           s1_d_reg;

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            num_next[l] = 96'(pl_reg[l]) + {ph_reg[l], 32'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            l2_d_reg <= l2_c_reg;
            s1_d_reg <= s1_c_reg;
        end
    end

    // projection divider
    logic [5:0][PQ-1:0] pq_w;
    side1_t             d1_reg [PQ];

    sec_proj_div u_proj_div (
        .clk  (clk),
        .en   (en),
        .num  (num_reg),
        .den  (l2_d_reg),
        .quot (pq_w)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg[0] <= s1_d_reg;
            for (int k = 1; k < PQ; k++)
            begin
                d1_reg[k] <= d1_reg[k-1];
            end
        end
    end

    // stage e: signed normal parts
    logic [5:0][33:0] nrm_next;
    logic [5:0][33:0] nrm_reg;
    side1_t           s1_e_reg;

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            nrm_next[l] = d1_reg[PQ-1].nneg[l] ? 34'(-{1'b0, pq_w[l]}) : {1'b0, pq_w[l]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_reg  <= nrm_next;
            s1_e_reg <= d1_reg[PQ-1];
        end
    end

    // stage f: mass products
    logic [5:0][16:0] mdiff_w;
    logic [5:0][17:0] mtwo_w;
    logic [5:0][33:0] oth_w;
    logic [5:0][51:0] p1_next;
    logic [5:0][51:0] p2_next;
    logic [16:0]      ms_next;
    side2_t           s2_f_next;

    logic [5:0][51:0] p1_reg;
    logic [5:0][51:0] p2_reg;
    logic [16:0]      ms_f_reg;
    side2_t           s2_f_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mdiff_w[i]   = {1'b0, s1_e_reg.kin.ma} - {1'b0, s1_e_reg.kin.mb};
            mdiff_w[3+i] = {1'b0, s1_e_reg.kin.mb} - {1'b0, s1_e_reg.kin.ma};
            mtwo_w[i]    = {1'b0, s1_e_reg.kin.mb, 1'b0};
            mtwo_w[3+i]  = {1'b0, s1_e_reg.kin.ma, 1'b0};
            oth_w[i]     = nrm_reg[3+i];
            oth_w[3+i]   = nrm_reg[i];
        end
        for (int l = 0; l < 6; l++)
        begin
            p1_next[l] = 52'($signed(nrm_reg[l])) * 52'($signed(mdiff_w[l]));
            p2_next[l] = 52'($signed(oth_w[l])) * 52'($signed(mtwo_w[l]));
        end
        ms_next           = 17'(s1_e_reg.kin.ma) + 17'(s1_e_reg.kin.mb);
        s2_f_next.vel     = s1_e_reg.kin.vel;
        s2_f_next.nrm     = nrm_reg;
        s2_f_next.contact = s1_e_reg.contact;
        s2_f_next.ms_zero = (ms_next == '0);
        s2_f_next.xneg    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            ms_f_reg <= ms_next;
            s2_f_reg <= s2_f_next;
        end
    end

    // stage g: mass numerator magnitude and sign
    logic [5:0][52:0] msum_w;
    logic [5:0][51:0] mnum_next;
    side2_t           s2_g_next;

    logic [5:0][51:0] mnum_reg;
    logic [16:0]      ms_g_reg;
    side2_t           s2_g_reg;

    always_comb
    begin
        s2_g_next = s2_f_reg;
        for (int l = 0; l < 6; l++)
        begin
            msum_w[l]         = 53'($signed(p1_reg[l])) + 53'($signed(p2_reg[l]));
            s2_g_next.xneg[l] = msum_w[l][52];
            mnum_next[l]      = msum_w[l][52] ? 52'(-msum_w[l]) : 52'(msum_w[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mnum_reg <= mnum_next;
            ms_g_reg <= ms_f_reg;
            s2_g_reg <= s2_g_next;
        end
    end

    // mass divider
    logic [5:0][MQ-1:0] mq_w;
    side2_t             d2_reg [MQ];

    sec_mass_div u_mass_div (
        .clk  (clk),
        .en   (en),
        .num  (mnum_reg),
        .den  (ms_g_reg),
        .quot (mq_w)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg[0] <= s2_g_reg;
            for (int k = 1; k < MQ; k++)
            begin
                d2_reg[k] <= d2_reg[k-1];
            end
        end
    end

    // stage h: new normal parts
    logic [5:0][35:0] x_next;
    logic [5:0][35:0] x_reg;
    side2_t           s2_h_reg;

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            if (d2_reg[MQ-1].ms_zero)
            begin
                x_next[l] = 36'($signed(d2_reg[MQ-1].nrm[l]));
            end
            else if (d2_reg[MQ-1].xneg[l])
            begin
                x_next[l] = 36'(-{1'b0, mq_w[l]});
            end
            else
            begin
                x_next[l] = {1'b0, mq_w[l]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            s2_h_reg <= d2_reg[MQ-1];
        end
    end

    // output stage: recombine and saturate
    logic [5:0][36:0] fsum_w;
    logic [5:0][31:0] nv_w;
    sec_pkg::result_t out_next;
    sec_pkg::result_t out_reg;

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            fsum_w[l] = 37'($signed(s2_h_reg.vel[l])) - 37'($signed(s2_h_reg.nrm[l]))
                      + 37'($signed(x_reg[l]));
            nv_w[l]   = s2_h_reg.contact ? sat32(fsum_w[l]) : s2_h_reg.vel[l];
        end
        out_next.new_vel_a_x = nv_w[0];
        out_next.new_vel_a_y = nv_w[1];
        out_next.new_vel_a_z = nv_w[2];
        out_next.new_vel_b_x = nv_w[3];
        out_next.new_vel_b_y = nv_w[4];
        out_next.new_vel_b_z = nv_w[5];
        out_next.contact     = s2_h_reg.contact;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

`default_nettype wire

>>> rtl/sec_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sphere_elastic_collision_assert.svh"

module sec_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    input  logic              pair_stall,
    input  logic              result_valid,
    input  logic              result_stall,
    input  sec_pkg::result_t  result
);

    // a stalled result holds
    `SEC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // the request side is held back only by a blocked result
    `SEC_ASSERT_IMPL(a_stall_cause, clk, rst_n, pair_stall, result_valid && result_stall)

    // with no result waiting a request is taken
    `SEC_ASSERT_IMPL(a_take, clk, rst_n, pair_valid && !result_valid, !pair_stall)

    // a result leaves only when taken
    `SEC_ASSERT_IMPL(a_no_drop, clk, rst_n, $fell(result_valid), $past(!result_stall))

endmodule

bind sphere_elastic_collision sec_checker u_sec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
